// File: rtl/core/hsec_pkg.sv
// Package with shared constants and elaboration-time helpers for the Hamming SEC block.
`timescale 1ns / 1ps

package hsec_pkg;

    localparam int MAX_CODE_BITS_DEF = 63;
    localparam int DATA_LIMIT_CAP    = 57;
    localparam int CFG_W             = 6;
    localparam int DATA_LENGTH_RESET = 4;
    localparam int APB_DATA_W        = 32;
    localparam int APB_ADDR_W        = 2;

    localparam logic [APB_ADDR_W-1:0] REG_DATA_LENGTH = 2'd0;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_CHECK  = 1'b1;

    // Least r with 2^r >= m + r + 1, capped at seven.
    function automatic int check_bits(input int m);
        int res;
        res = 0;
        for (int i = 0; i < 7; i++) begin
            if (res == i && (1 << i) < m + i + 1) begin
                res = i + 1;
            end
        end
        return res;
    endfunction

    // Largest data length whose codeword fits in maxc positions.
    function automatic int max_data(input int maxc);
        int res;
        res = 1;
        for (int m = 1; m <= DATA_LIMIT_CAP; m++) begin
            if (m + check_bits(m) <= maxc) begin
                res = m;
            end
        end
        return res;
    endfunction

    // A zero length counts as one, and a long one saturates at the limit.
    function automatic int eff_m(input int raw, input int lim);
        int res;
        res = raw;
        if (raw == 0) begin
            res = 1;
        end else if (raw > lim) begin
            res = lim;
        end
        return res;
    endfunction

    function automatic logic [63:0] low_mask64(input int n);
        logic [63:0] res;
        if (n >= 64) begin
            res = '1;
        end else begin
            res = (64'd1 << n) - 64'd1;
        end
        return res;
    endfunction

    function automatic bit is_pow2(input int k);
        return (k & (k - 1)) == 0;
    endfunction

    function automatic int flog2(input int k);
        int res;
        res = 0;
        for (int i = 0; i < 7; i++) begin
            if ((k >> i) != 0) begin
                res = i;
            end
        end
        return res;
    endfunction

    // Data bit that lands at a position which is not a power of two.
    function automatic int data_index(input int k);
        return k - 2 - flog2(k);
    endfunction

    // Positions 1..63 whose index has bit i set; bit k-1 stands for position k.
    function automatic logic [63:0] syn_pos_mask(input int i);
        logic [63:0] res;
        res = '0;
        for (int k = 1; k < 64; k++) begin
            if (((k >> i) & 1) != 0) begin
                res[k-1] = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

// File: rtl/core/hsec_in_if.sv
// Interface for the input channel of the Hamming SEC block.
`timescale 1ns / 1ps

interface hsec_in_if #(
    parameter int DATA_W = hsec_pkg::max_data(hsec_pkg::MAX_CODE_BITS_DEF),
    parameter int CODE_W = hsec_pkg::MAX_CODE_BITS_DEF
);
    logic              valid;
    logic              ready;
    logic              command;
    logic [DATA_W-1:0] data_bits;
    logic [CODE_W-1:0] code_bits;

    modport source (output valid, output command, output data_bits, output code_bits,
                    input ready);
    modport sink (input valid, input command, input data_bits, input code_bits,
                  output ready);
endinterface

// File: rtl/core/hsec_out_if.sv
// Interface for the result channel of the Hamming SEC block.
`timescale 1ns / 1ps

interface hsec_out_if #(
    parameter int CODE_W = hsec_pkg::MAX_CODE_BITS_DEF,
    parameter int SYN_W  = $clog2(hsec_pkg::MAX_CODE_BITS_DEF + 1)
);
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] codeword;
    logic [SYN_W-1:0]  syndrome;
    logic              error_detected;
    logic              uncorrectable;

    modport source (output valid, output codeword, output syndrome,
                    output error_detected, output uncorrectable, input ready);
    modport sink (input valid, input codeword, input syndrome,
                  input error_detected, input uncorrectable, output ready);
endinterface

// File: rtl/core/hsec_cfg.sv
// APB register for the data length and the code geometry derived from it.
`timescale 1ns / 1ps

module hsec_cfg #(
    parameter int DATA_W = 57,
    parameter int CODE_W = 63,
    parameter int SYN_W  = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hsec_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [hsec_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [hsec_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [DATA_W-1:0]                   o_data_mask,
    output logic [CODE_W-1:0]                   o_code_mask,
    output logic [SYN_W-1:0]                    o_code_len
);

    localparam int RST_M = hsec_pkg::eff_m(hsec_pkg::DATA_LENGTH_RESET, DATA_W);
    localparam int RST_N = RST_M + hsec_pkg::check_bits(RST_M);

    logic [hsec_pkg::CFG_W-1:0] r_data_length, n_data_length;
    logic [DATA_W-1:0]          r_data_mask, n_data_mask;
    logic [CODE_W-1:0]          r_code_mask, n_code_mask;
    logic [SYN_W-1:0]           r_code_len, n_code_len;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == hsec_pkg::REG_DATA_LENGTH);

    always_comb begin
        int m;
        int n;
        n_data_length = wr_en ? pwdata[hsec_pkg::CFG_W-1:0] : r_data_length;
        m = hsec_pkg::eff_m(int'(n_data_length), DATA_W);
        n = m + hsec_pkg::check_bits(m);
        n_data_mask = DATA_W'(hsec_pkg::low_mask64(m));
        n_code_mask = CODE_W'(hsec_pkg::low_mask64(n));
        n_code_len  = SYN_W'(n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_length <= hsec_pkg::CFG_W'(hsec_pkg::DATA_LENGTH_RESET);
            r_data_mask   <= DATA_W'(hsec_pkg::low_mask64(RST_M));
            r_code_mask   <= CODE_W'(hsec_pkg::low_mask64(RST_N));
            r_code_len    <= SYN_W'(RST_N);
        end else begin
            r_data_length <= n_data_length;
            r_data_mask   <= n_data_mask;
            r_code_mask   <= n_code_mask;
            r_code_len    <= n_code_len;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == hsec_pkg::REG_DATA_LENGTH) begin
            prdata[hsec_pkg::CFG_W-1:0] = r_data_length;
        end
    end

    assign o_data_mask = r_data_mask;
    assign o_code_mask = r_code_mask;
    assign o_code_len  = r_code_len;

endmodule

// File: rtl/core/hsec_codec.sv
// Combinational Hamming encoder and single-error corrector.
`timescale 1ns / 1ps

module hsec_codec #(
    parameter int DATA_W = 57,
    parameter int CODE_W = 63,
    parameter int SYN_W  = 6
) (
    input  logic              i_command,
    input  logic [DATA_W-1:0] i_data_bits,
    input  logic [CODE_W-1:0] i_code_bits,
    input  logic [DATA_W-1:0] i_data_mask,
    input  logic [CODE_W-1:0] i_code_mask,
    input  logic [SYN_W-1:0]  i_code_len,
    output logic [CODE_W-1:0] o_codeword,
    output logic [SYN_W-1:0]  o_syndrome,
    output logic              o_error_detected,
    output logic              o_uncorrectable
);

    logic [DATA_W-1:0] data_m;
    logic [CODE_W-1:0] enc_raw;
    logic [CODE_W-1:0] enc_word;
    logic [CODE_W-1:0] chk_word;
    logic [CODE_W-1:0] flip;
    logic [SYN_W-1:0]  enc_par;
    logic [SYN_W-1:0]  chk_syn;
    logic              chk_unc;

    assign data_m   = i_data_bits & i_data_mask;
    assign chk_word = i_code_bits & i_code_mask;
    assign chk_unc  = chk_syn > i_code_len;

    for (genvar k = 1; k <= CODE_W; k++) begin : g_pos
        if (hsec_pkg::is_pow2(k)) begin : g_chk
            assign enc_raw[k-1]  = 1'b0;
            assign enc_word[k-1] = enc_par[hsec_pkg::flog2(k)];
        end else begin : g_dat
            assign enc_raw[k-1]  = data_m[hsec_pkg::data_index(k)];
            assign enc_word[k-1] = enc_raw[k-1];
        end
        assign flip[k-1] = (chk_syn == SYN_W'(k)) && !chk_unc;
    end

    for (genvar i = 0; i < SYN_W; i++) begin : g_syn
        localparam logic [CODE_W-1:0] PosMask = CODE_W'(hsec_pkg::syn_pos_mask(i));
        assign enc_par[i] = ^(enc_raw & PosMask);
        assign chk_syn[i] = ^(chk_word & PosMask);
    end

    always_comb begin
        if (i_command == hsec_pkg::CMD_CHECK) begin
            o_codeword       = chk_word ^ flip;
            o_syndrome       = chk_syn;
            o_error_detected = |chk_syn;
            o_uncorrectable  = chk_unc;
        end else begin
            o_codeword       = enc_word & i_code_mask;
            o_syndrome       = '0;
            o_error_detected = 1'b0;
            o_uncorrectable  = 1'b0;
        end
    end

endmodule

// File: rtl/core/hamming_sec_encode_correct_core.sv
// Top level of the even-parity Hamming single-error-correcting encoder and checker.
`timescale 1ns / 1ps

// The block takes one word per cycle unless the output stalls, and returns one result
// word for each: an input register feeds the parity trees, the syndrome compare and the
// correcting XOR, and a result register holds the answer until it is taken. A stalled
// output holds both stages, and the input stays ready while the input register can
// move on. The data length register at address 0 sets the code geometry; the user
// must write it only while no words are in flight, as the block does not enforce it.
module hamming_sec_encode_correct_core #(
    parameter int MAX_CODE_BITS = hsec_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    hsec_in_if.sink                         i_in,
    hsec_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hsec_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [hsec_pkg::APB_DATA_W-1:0] pwdata,
    output logic [hsec_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int CODE_W = MAX_CODE_BITS;
    localparam int DATA_W = hsec_pkg::max_data(MAX_CODE_BITS);
    localparam int SYN_W  = $clog2(MAX_CODE_BITS + 1);

    logic [DATA_W-1:0] data_mask;
    logic [CODE_W-1:0] code_mask;
    logic [SYN_W-1:0]  code_len;

    logic              r_s1_valid;
    logic              r_s1_cmd;
    logic [DATA_W-1:0] r_s1_data;
    logic [CODE_W-1:0] r_s1_code;

    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_codeword;
    logic [SYN_W-1:0]  r_out_syndrome;
    logic              r_out_err;
    logic              r_out_unc;

    logic [CODE_W-1:0] n_out_codeword;
    logic [SYN_W-1:0]  n_out_syndrome;
    logic              n_out_err;
    logic              n_out_unc;

    logic              s1_adv;
    logic              in_take;

    hsec_cfg #(
        .DATA_W (DATA_W),
        .CODE_W (CODE_W),
        .SYN_W  (SYN_W)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_data_mask (data_mask),
        .o_code_mask (code_mask),
        .o_code_len  (code_len)
    );

    hsec_codec #(
        .DATA_W (DATA_W),
        .CODE_W (CODE_W),
        .SYN_W  (SYN_W)
    ) u_codec (
        .i_command        (r_s1_cmd),
        .i_data_bits      (r_s1_data),
        .i_code_bits      (r_s1_code),
        .i_data_mask      (data_mask),
        .i_code_mask      (code_mask),
        .i_code_len       (code_len),
        .o_codeword       (n_out_codeword),
        .o_syndrome       (n_out_syndrome),
        .o_error_detected (n_out_err),
        .o_uncorrectable  (n_out_unc)
    );

    assign s1_adv     = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_cmd  <= i_in.command;
            r_s1_data <= i_in.data_bits;
            r_s1_code <= i_in.code_bits;
        end
        if (s1_adv && r_s1_valid) begin
            r_out_codeword <= n_out_codeword;
            r_out_syndrome <= n_out_syndrome;
            r_out_err      <= n_out_err;
            r_out_unc      <= n_out_unc;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.codeword       = r_out_codeword;
    assign o_out.syndrome       = r_out_syndrome;
    assign o_out.error_detected = r_out_err;
    assign o_out.uncorrectable  = r_out_unc;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the Hamming SEC encoder and checker with APB length setup.
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_HALF       = 2;
    localparam int MAX_DATA_BITS  = 57;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int IDLE_PCT       = 26;
    localparam int PHASE_COUNT    = 12;
    localparam int PHASE_WORDS    = 150;
    localparam int STEADY_PHASE   = 3;
    localparam int HOLD_AFTER     = 300;
    localparam int HOLD_CYCLES    = 120;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [56:0] ALL_DATA = 57'h1FF_FFFF_FFFF_FFFF;
    localparam logic [62:0] ALL_CODE = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [62:0] TOP_CODE = 63'h4000_0000_0000_0000;

    typedef struct packed {
        logic [62:0] codeword;
        logic [5:0]  syndrome;
        logic        error_detected;
        logic        uncorrectable;
    } ecc_result_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PRED,
        ROW_TYPED
    } row_kind_e;

    typedef struct packed {
        row_kind_e   kind;
        logic [5:0]  len;
        logic        cmd;
        logic [56:0] data;
        logic [62:0] code;
        ecc_result_t want;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [25] = '{
        '{ROW_TYPED, 6'd0, hsec_pkg::CMD_ENCODE, 57'h0, 63'h0, '{63'h0, 6'd0, 1'b0, 1'b0}},
        '{ROW_TYPED, 6'd0, hsec_pkg::CMD_ENCODE, ALL_DATA, 63'h0, '{63'h7F, 6'd0, 1'b0, 1'b0}},
        '{ROW_TYPED, 6'd0, hsec_pkg::CMD_CHECK, 57'h0, 63'h0, '{63'h0, 6'd0, 1'b0, 1'b0}},
        '{ROW_TYPED, 6'd0, hsec_pkg::CMD_CHECK, 57'h0, ALL_CODE, '{63'h7F, 6'd0, 1'b0, 1'b0}},
        '{ROW_TYPED, 6'd0, hsec_pkg::CMD_CHECK, 57'h0, 63'h1, '{63'h0, 6'd1, 1'b1, 1'b0}},
        '{ROW_TYPED, 6'd0, hsec_pkg::CMD_CHECK, 57'h0, 63'h7E, '{63'h7F, 6'd1, 1'b1, 1'b0}},
        '{ROW_PRED, 6'd0, hsec_pkg::CMD_ENCODE, 57'h5, 63'h0, '0},
        '{ROW_PRED, 6'd0, hsec_pkg::CMD_CHECK, 57'h0, 63'h35, '0},
        '{ROW_CFG, 6'd0, hsec_pkg::CMD_ENCODE, 57'h0, 63'h0, '0},
        '{ROW_TYPED, 6'd0, hsec_pkg::CMD_ENCODE, ALL_DATA, 63'h0, '{63'h7, 6'd0, 1'b0, 1'b0}},
        '{ROW_TYPED, 6'd0, hsec_pkg::CMD_CHECK, 57'h0, 63'h4, '{63'h0, 6'd3, 1'b1, 1'b0}},
        '{ROW_CFG, 6'd5, hsec_pkg::CMD_ENCODE, 57'h0, 63'h0, '0},
        '{ROW_TYPED, 6'd0, hsec_pkg::CMD_CHECK, 57'h0, 63'h82, '{63'h82, 6'd10, 1'b1, 1'b1}},
        '{ROW_PRED, 6'd0, hsec_pkg::CMD_CHECK, 57'h0, ALL_CODE, '0},
        '{ROW_PRED, 6'd0, hsec_pkg::CMD_ENCODE, ALL_DATA, 63'h0, '0},
        '{ROW_CFG, 6'd57, hsec_pkg::CMD_ENCODE, 57'h0, 63'h0, '0},
        '{ROW_TYPED, 6'd0, hsec_pkg::CMD_ENCODE, ALL_DATA, 63'h0, '{ALL_CODE, 6'd0, 1'b0, 1'b0}},
        '{ROW_TYPED, 6'd0, hsec_pkg::CMD_CHECK, 57'h0, ALL_CODE, '{ALL_CODE, 6'd0, 1'b0, 1'b0}},
        '{ROW_TYPED, 6'd0, hsec_pkg::CMD_CHECK, 57'h0, TOP_CODE, '{63'h0, 6'd63, 1'b1, 1'b0}},
        '{ROW_PRED, 6'd0, hsec_pkg::CMD_ENCODE, 57'h155_5555_5555_5555, 63'h0, '0},
        '{ROW_CFG, 6'd63, hsec_pkg::CMD_ENCODE, 57'h0, 63'h0, '0},
        '{ROW_TYPED, 6'd0, hsec_pkg::CMD_ENCODE, ALL_DATA, 63'h0, '{ALL_CODE, 6'd0, 1'b0, 1'b0}},
        '{ROW_CFG, 6'd58, hsec_pkg::CMD_ENCODE, 57'h0, 63'h0, '0},
        '{ROW_PRED, 6'd0, hsec_pkg::CMD_CHECK, 57'h0, 63'h2AAA_AAAA_AAAA_AAAA, '0},
        '{ROW_CFG, 6'd4, hsec_pkg::CMD_ENCODE, 57'h0, 63'h0, '0}
    };

    localparam logic [5:0] PHASE_LEN [PHASE_COUNT] = '{
        6'd1, 6'd2, 6'd3, 6'd57, 6'd63, 6'd0, 6'd58, 6'd5, 6'd11, 6'd26, 6'd36, 6'd20
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [hsec_pkg::APB_ADDR_W-1:0] paddr;
    logic [hsec_pkg::APB_DATA_W-1:0] pwdata;
    logic [hsec_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    hsec_in_if  in_if();
    hsec_out_if out_if();

    hamming_sec_encode_correct_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    ecc_result_t outcomes_due[$];
    logic [5:0]  cur_len = 6'(hsec_pkg::DATA_LENGTH_RESET);
    int          mismatches = 0;
    int          results_seen = 0;
    int          stalled = 0;
    bit          no_idle = 1'b0;

    function automatic int code_length(input logic [5:0] len);
        int m;
        int r;
        m = int'(len);
        if (m == 0) begin
            m = 1;
        end else if (m > MAX_DATA_BITS) begin
            m = MAX_DATA_BITS;
        end
        r = 0;
        while ((1 << r) < m + r + 1) begin
            r++;
        end
        return m + r;
    endfunction

    function automatic ecc_result_t hamming_outcome(input logic [5:0] len, input logic cmd,
                                                    input logic [56:0] data,
                                                    input logic [62:0] code);
        ecc_result_t res;
        logic [62:0] word;
        logic [5:0]  syn;
        int          n;
        int          j;
        int          k;
        int          s;
        res = '0;
        word = '0;
        syn = '0;
        n = code_length(len);
        if (cmd == hsec_pkg::CMD_ENCODE) begin
            j = 0;
            for (k = 1; k <= n; k++) begin
                if ((k & (k - 1)) != 0) begin
                    word[k-1] = data[j];
                    j++;
                end
            end
            for (k = 1; k <= n; k++) begin
                if (word[k-1]) begin
                    syn = syn ^ 6'(k);
                end
            end
            for (k = 1; k <= n; k = k * 2) begin
                if ((int'(syn) & k) != 0) begin
                    word[k-1] = 1'b1;
                end
            end
        end else begin
            for (k = 1; k <= n; k++) begin
                word[k-1] = code[k-1];
                if (code[k-1]) begin
                    syn = syn ^ 6'(k);
                end
            end
            res.syndrome = syn;
            s = int'(syn);
            if (s != 0) begin
                res.error_detected = 1'b1;
                if (s <= n) begin
                    word[s-1] = ~word[s-1];
                end else begin
                    res.uncorrectable = 1'b1;
                end
            end
        end
        res.codeword = word;
        return res;
    endfunction

    task automatic send_word(input logic cmd, input logic [56:0] data,
                             input logic [62:0] code, input ecc_result_t want);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.command   <= cmd;
        in_if.data_bits <= data;
        in_if.code_bits <= code;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        outcomes_due.push_back(want);
    endtask

    // The length is changed only once the pipeline has drained.
    task automatic set_data_length(input logic [hsec_pkg::APB_DATA_W-1:0] value);
        in_if.valid <= 1'b0;
        while (outcomes_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= hsec_pkg::REG_DATA_LENGTH;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_len = value[5:0];
    endtask

    initial begin
        stim_row_t   row;
        ecc_result_t want;
        logic [63:0] wide;
        logic [63:0] code_mask;
        logic [62:0] clean;
        logic [56:0] data;
        logic [62:0] code;
        logic [5:0]  len;
        logic        cmd;
        int          n;
        int          kind;
        int          p1;
        int          p2;
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_if.valid     <= 1'b0;
        in_if.command   <= hsec_pkg::CMD_ENCODE;
        in_if.data_bits <= '0;
        in_if.code_bits <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[idx]) begin
            row = DIRECTED_ROWS[idx];
            if (row.kind == ROW_CFG) begin
                set_data_length({26'd0, row.len});
            end else begin
                if (row.kind == ROW_TYPED) begin
                    want = row.want;
                end else begin
                    want = hamming_outcome(cur_len, row.cmd, row.data, row.code);
                end
                send_word(row.cmd, row.data, row.code, want);
            end
        end

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            len = (phase >= 10) ? 6'($urandom_range(0, 63)) : PHASE_LEN[phase];
            wide = {$urandom, $urandom};
            set_data_length({($urandom_range(0, 1) == 1) ? wide[25:0] : 26'd0, len});
            no_idle = (phase == STEADY_PHASE);
            n = code_length(cur_len);
            code_mask = (64'd1 << n) - 64'd1;
            repeat (PHASE_WORDS) begin
                cmd  = 1'($urandom_range(0, 1));
                wide = {$urandom, $urandom};
                data = wide[56:0];
                wide = {$urandom, $urandom};
                code = wide[62:0];
                kind = $urandom_range(0, 99);
                // Mostly proper codewords with zero, one or two flipped bits.
                if (cmd == hsec_pkg::CMD_CHECK && kind < 82) begin
                    want = hamming_outcome(cur_len, hsec_pkg::CMD_ENCODE, data, '0);
                    clean = want.codeword;
                    if (kind >= 35) begin
                        p1 = $urandom_range(1, n);
                        clean[p1-1] = ~clean[p1-1];
                        if (kind >= 70) begin
                            p2 = $urandom_range(1, n - 1);
                            if (p2 >= p1) begin
                                p2++;
                            end
                            clean[p2-1] = ~clean[p2-1];
                        end
                    end
                    if ($urandom_range(0, 2) == 0) begin
                        clean = clean | (code & ~code_mask[62:0]);
                    end
                    code = clean;
                end
                send_word(cmd, data, code, hamming_outcome(cur_len, cmd, data, code));
            end
            no_idle = 1'b0;
        end

        in_if.valid <= 1'b0;
        while (outcomes_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && outcomes_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Result side: random back-pressure and one long hold while words keep coming.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        ecc_result_t got;
        ecc_result_t want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = '{out_if.codeword, out_if.syndrome, out_if.error_detected,
                    out_if.uncorrectable};
            results_seen++;
            if (outcomes_due.size() == 0) begin
                if (mismatches < REPORT_LIMIT) begin
                    $display("unexpected result word: cw=%h syn=%0d err=%b unc=%b",
                             got.codeword, got.syndrome, got.error_detected,
                             got.uncorrectable);
                end
                mismatches++;
            end else begin
                want = outcomes_due.pop_front();
                if (got !== want) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("mismatch: got cw=%h syn=%0d err=%b unc=%b", got.codeword,
                                 got.syndrome, got.error_detected, got.uncorrectable);
                        $display("          want cw=%h syn=%0d err=%b unc=%b", want.codeword,
                                 want.syndrome, want.error_detected, want.uncorrectable);
                    end
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stalled <= 0;
        end else if (stalled >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stalled <= stalled + 1;
        end
    end

endmodule
